### rtl/ultrasonic_motion_detector_defines.svh
// assertion macros shared by the motion detector rtl
`ifndef ULTRASONIC_MOTION_DETECTOR_DEFINES_SVH
`define ULTRASONIC_MOTION_DETECTOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define UMD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define UMD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### rtl/umd_pkg.sv
// shared types, constants and helpers of the motion detector
package umd_pkg;

   // millimeter value width (255 cm * 10 fits in 12 bits)
   localparam int MM_W     = 12;
   localparam int CM_W     = 8;
   localparam int THR_W    = 12;
   localparam int HITS_W   = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 12;
   localparam int REQ_DAT_W = 8;
   localparam int RSP_DAT_W = 40;

   // result fifo depth and the fixed pipeline length in front of it
   localparam int RSP_DEPTH  = 16;
   localparam int RSP_PTR_W  = 4;
   localparam int RSP_CNT_W  = 5;
   localparam int PIPE_DEPTH = 8;
   localparam int PIPE_CNT_W = 4;

   // reset values of the configuration registers
   localparam logic [THR_W-1:0]  THR_RESET  = 12'd100;
   localparam logic [HITS_W-1:0] HITS_RESET = 8'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_THRESHOLD = 1'b0,
      REG_HITS      = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_UNKNOWN = 3'b001,
      ST_MOTION  = 3'b010,
      ST_ENDED   = 3'b100
   } state_type;

   // one result item, motion in the lowest bit
   typedef struct packed {
      logic [HITS_W-1:0] hit_count;
      logic [MM_W-1:0]   mean_deviation_mm;
      logic [MM_W-1:0]   mean_distance_mm;
      logic              changed;
      logic              motion;
   } result_type;

   // cm to mm as shift and add: 10 = 8 + 2
   function automatic logic [MM_W-1:0] mm_from_cm(input logic [CM_W-1:0] cm);
      logic [MM_W-1:0] wide;
      wide = MM_W'(cm);
      return (wide << 3) + (wide << 1);
   endfunction

endpackage

### rtl/umd_window.sv
// sliding window: ring memory with read-first update, running sum and fill count
module umd_window #(
   parameter int WINDOW = 8
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            push_valid,
   input  logic [umd_pkg::MM_W-1:0]                        push_value,
   output logic                                            out_valid,
   output logic                                            out_full,
   output logic [umd_pkg::MM_W+$clog2(WINDOW)-1:0]         out_sum
);

   localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int SUM_W  = umd_pkg::MM_W + $clog2(WINDOW);

   logic [umd_pkg::MM_W-1:0] ring_mem [WINDOW];
   logic [umd_pkg::MM_W-1:0] old_ff;
   logic [umd_pkg::MM_W-1:0] val_ff;
   logic [PTR_W-1:0]         ptr_ff, ptr_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic                     s1_valid_ff, s1_full_ff, old_live_ff;
   logic [SUM_W-1:0]         sum_ff, sum_in, old_term;
   logic                     valid_ff, full_ff;

   // read the leaving entry and write the new one at the same address
   always_ff @(posedge clock) begin
      if (push_valid) begin
         old_ff            <= ring_mem[ptr_ff];
         ring_mem[ptr_ff]  <= push_value;
         val_ff            <= push_value;
      end
   end

   // pointer wraps at the window size, fill saturates there
   always_comb begin
      ptr_in  = (ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
      fill_in = (fill_ff == FILL_W'(WINDOW)) ? fill_ff : fill_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         fill_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s1_full_ff  <= 1'b0;
         old_live_ff <= 1'b0;
      end else begin
         s1_valid_ff <= push_valid;
         if (push_valid) begin
            ptr_ff      <= ptr_in;
            fill_ff     <= fill_in;
            // an entry read before the window filled was never written: counts as zero
            old_live_ff <= (fill_ff == FILL_W'(WINDOW));
            s1_full_ff  <= (fill_ff >= FILL_W'(WINDOW - 1));
         end
      end
   end

   // running sum updated in the cycle after the memory access
   always_comb begin
      old_term = old_live_ff ? SUM_W'(old_ff) : '0;
      sum_in   = sum_ff - old_term + SUM_W'(val_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         valid_ff <= 1'b0;
         full_ff  <= 1'b0;
      end else begin
         valid_ff <= s1_valid_ff;
         full_ff  <= s1_full_ff;
         if (s1_valid_ff) begin
            sum_ff <= sum_in;
         end
      end
   end

   assign out_valid = valid_ff;
   assign out_full  = full_ff;
   assign out_sum   = sum_ff;

endmodule

### rtl/umd_mean_div.sv
// window mean: truncating divide by the window size via reciprocal and one correction
module umd_mean_div #(
   parameter int WINDOW = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  logic [umd_pkg::MM_W+$clog2(WINDOW)-1:0] in_sum,
   output logic                                    out_valid,
   output logic [umd_pkg::MM_W-1:0]                out_mean
);

   localparam int SUM_W  = umd_pkg::MM_W + $clog2(WINDOW);
   localparam int SHIFT  = SUM_W + 1;
   localparam int PROD_W = SUM_W + SHIFT + 1;
   localparam logic [SHIFT:0] RECIP = (SHIFT + 1)'((64'd1 << SHIFT) / WINDOW);

   logic [PROD_W-1:0]        prod;
   logic [umd_pkg::MM_W-1:0] q0_ff;
   logic [SUM_W-1:0]         sum_a_ff;
   logic                     valid_a_ff;
   logic [SUM_W-1:0]         q_times_w, rem;
   logic [umd_pkg::MM_W-1:0] mean_in, mean_ff;
   logic                     valid_ff;

   // first stage: estimate, never above the true quotient and at most one below
   assign prod = PROD_W'(in_sum) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      q0_ff    <= prod[SHIFT +: umd_pkg::MM_W];
      sum_a_ff <= in_sum;
   end

   // second stage: remainder check and correction
   always_comb begin
      q_times_w = SUM_W'(q0_ff) * SUM_W'(WINDOW);
      rem       = sum_a_ff - q_times_w;
      mean_in   = (rem >= SUM_W'(WINDOW)) ? q0_ff + 1'b1 : q0_ff;
   end

   always_ff @(posedge clock) begin
      mean_ff <= mean_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
         valid_ff   <= valid_a_ff;
      end
   end

   assign out_valid = valid_ff;
   assign out_mean  = mean_ff;

endmodule

### rtl/umd_hit_tracker.sv
// hit counter and motion state, builds one result per evaluated sample
module umd_hit_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [umd_pkg::MM_W-1:0]    mean_distance,
   input  logic [umd_pkg::MM_W-1:0]    mean_deviation,
   input  logic [umd_pkg::THR_W-1:0]   threshold,
   input  logic [umd_pkg::HITS_W-1:0]  hits,
   output logic                        res_valid,
   output umd_pkg::result_type         res_data
);

   logic [umd_pkg::HITS_W-1:0] count_ff, count_in;
   umd_pkg::state_type         cur_ff, cur_in, prev_ff, prev_in;
   logic                       above, below;

   // counter steps up on a hit below the ceiling, else down when at or below
   always_comb begin
      above = (mean_deviation >= threshold);
      below = (mean_deviation <= threshold);
      count_in = count_ff;
      priority if (above && (count_ff < hits)) begin
         count_in = count_ff + 1'b1;
      end else if (below && (count_ff != '0)) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   // state moves only at the counter limits
   always_comb begin
      cur_in  = cur_ff;
      prev_in = prev_ff;
      priority if (count_in >= hits) begin
         prev_in = cur_ff;
         cur_in  = umd_pkg::ST_MOTION;
      end else if (count_in == '0) begin
         prev_in = cur_ff;
         cur_in  = umd_pkg::ST_ENDED;
      end else begin
         prev_in = prev_ff;
         cur_in  = cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cur_ff   <= umd_pkg::ST_UNKNOWN;
         prev_ff  <= umd_pkg::ST_UNKNOWN;
      end else if (in_valid) begin
         count_ff <= count_in;
         cur_ff   <= cur_in;
         prev_ff  <= prev_in;
      end
   end

   // result item from the updated state
   always_comb begin
      res_data.motion            = (cur_in == umd_pkg::ST_MOTION);
      res_data.changed           = (cur_in != prev_in);
      res_data.mean_distance_mm  = mean_distance;
      res_data.mean_deviation_mm = mean_deviation;
      res_data.hit_count         = count_in;
   end

   assign res_valid = in_valid;

endmodule

### rtl/umd_rsp_fifo.sv
// result fifo between the pipeline and the result channel
module umd_rsp_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  umd_pkg::result_type            push_data,
   input  logic                           pop,
   output logic                           not_empty,
   output umd_pkg::result_type            head_data,
   output logic [umd_pkg::RSP_CNT_W-1:0]  count
);

   umd_pkg::result_type              slot_ff [umd_pkg::RSP_DEPTH];
   logic [umd_pkg::RSP_PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [umd_pkg::RSP_CNT_W-1:0]    count_ff, count_in;
   logic                             do_pop;

   assign do_pop = pop && (count_ff != '0);

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // occupancy
   always_comb begin
      count_in = count_ff;
      unique case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

### rtl/ultrasonic_motion_detector.sv
// top level of the ultrasonic motion detector
//
// req channel: one distance sample per item, req_tdata holds the distance in cm and
// req_tuser flags a sample with no echo; such a sample is taken and dropped.
// rsp channel: one item per evaluated sample, once both sliding windows are full.
// csr channel: index 0 writes the deviation threshold in mm, index 1 the hit count
// that declares motion; always ready. It must be written by the user between runs
// of samples; the block itself does not enforce this.
// Pipeline: each window registers its ring memory access, then its sum update; each
// mean its reciprocal multiply, then its correction; then the hit counter and fifo.
// Throughput: one sample per cycle while req_tready is high; consecutive samples need
// no interlock: each ring memory is read and written at one address in the same cycle.
// Stall: results collect in a 16-entry fifo; req_tready stays high while the fifo
// plus the samples in flight leave room, so a stalled receiver stops input only
// once 16 items are owed.
// Reset: windows empty, hit count zero, state unknown, threshold 100, hit count 3;
// the ring memories are not cleared, their fill counts mask old contents.
module ultrasonic_motion_detector #(
   parameter int DIST_WINDOW = 8,
   parameter int DEV_WINDOW  = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // sample input
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [umd_pkg::REQ_DAT_W-1:0]     req_tdata,  // [7:0] distance_cm
   input  logic [0:0]                        req_tuser,  // [0] out_of_range
   // result output
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [umd_pkg::RSP_DAT_W-1:0]     rsp_tdata,  // [0] motion, [1] changed,
                                                          // [13:2] mean_distance_mm,
                                                          // [25:14] mean_deviation_mm,
                                                          // [33:26] hit_count, rest zero
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [umd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [umd_pkg::CSR_DAT_W-1:0]     csr_data
);

   `include "ultrasonic_motion_detector_defines.svh"

   localparam int DSUM_W = umd_pkg::MM_W + $clog2(DIST_WINDOW);
   localparam int VSUM_W = umd_pkg::MM_W + $clog2(DEV_WINDOW);
   localparam int CREDIT_W = umd_pkg::RSP_CNT_W + 1;

   logic [umd_pkg::THR_W-1:0]  thr_ff;
   logic [umd_pkg::HITS_W-1:0] hits_ff;

   logic                        sample_take;
   logic [umd_pkg::MM_W-1:0]    sample_mm;
   logic [umd_pkg::MM_W-1:0]    mm_pipe_ff [4];
   logic [umd_pkg::MM_W-1:0]    mean_d_pipe_ff [4];
   logic [umd_pkg::PIPE_DEPTH-1:0] mark_ff;
   logic [umd_pkg::PIPE_CNT_W-1:0] inflight;
   logic [CREDIT_W-1:0]         credit;

   logic                        dwin_valid, dwin_full;
   logic [DSUM_W-1:0]           dwin_sum;
   logic                        ddiv_valid;
   logic [umd_pkg::MM_W-1:0]    ddiv_mean;
   logic [umd_pkg::MM_W-1:0]    dev_value;
   logic                        vwin_valid, vwin_full;
   logic [VSUM_W-1:0]           vwin_sum;
   logic                        vdiv_valid;
   logic [umd_pkg::MM_W-1:0]    vdiv_mean;

   logic                        res_valid;
   umd_pkg::result_type         res_data;
   umd_pkg::result_type         head_data;
   logic [umd_pkg::RSP_CNT_W-1:0] fifo_count;
   logic                        fifo_not_empty;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= umd_pkg::THR_RESET;
         hits_ff <= umd_pkg::HITS_RESET;
      end else if (csr_valid) begin
         unique case (umd_pkg::csr_index_type'(csr_index))
            umd_pkg::REG_THRESHOLD: thr_ff  <= csr_data;
            umd_pkg::REG_HITS:      hits_ff <= csr_data[umd_pkg::HITS_W-1:0];
            default:                thr_ff  <= thr_ff;
         endcase
      end
   end

   // accept while fifo plus in-flight samples leave a free slot
   assign inflight   = umd_pkg::PIPE_CNT_W'($countones(mark_ff));
   assign credit     = CREDIT_W'(fifo_count) + CREDIT_W'(inflight);
   assign req_tready = (credit < CREDIT_W'(umd_pkg::RSP_DEPTH));

   assign sample_take = req_tvalid && req_tready && !req_tuser[0];
   assign sample_mm   = umd_pkg::mm_from_cm(req_tdata[umd_pkg::CM_W-1:0]);

   // in-flight marks, one per sample until it reaches the hit counter
   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= '0;
      end else begin
         mark_ff <= {mark_ff[umd_pkg::PIPE_DEPTH-2:0], sample_take};
      end
   end

   // sample value carried alongside the distance window and mean
   always_ff @(posedge clock) begin
      mm_pipe_ff[0] <= sample_mm;
      mm_pipe_ff[1] <= mm_pipe_ff[0];
      mm_pipe_ff[2] <= mm_pipe_ff[1];
      mm_pipe_ff[3] <= mm_pipe_ff[2];
   end

   umd_window #(.WINDOW(DIST_WINDOW)) u_dist_window (
      .clock      (clock),
      .reset      (reset),
      .push_valid (sample_take),
      .push_value (sample_mm),
      .out_valid  (dwin_valid),
      .out_full   (dwin_full),
      .out_sum    (dwin_sum)
   );

   umd_mean_div #(.WINDOW(DIST_WINDOW)) u_dist_mean (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dwin_valid && dwin_full),
      .in_sum    (dwin_sum),
      .out_valid (ddiv_valid),
      .out_mean  (ddiv_mean)
   );

   // absolute deviation of the sample from the distance mean
   assign dev_value = (mm_pipe_ff[3] > ddiv_mean) ? mm_pipe_ff[3] - ddiv_mean
                                                  : ddiv_mean - mm_pipe_ff[3];

   // distance mean carried alongside the deviation window and mean
   always_ff @(posedge clock) begin
      mean_d_pipe_ff[0] <= ddiv_mean;
      mean_d_pipe_ff[1] <= mean_d_pipe_ff[0];
      mean_d_pipe_ff[2] <= mean_d_pipe_ff[1];
      mean_d_pipe_ff[3] <= mean_d_pipe_ff[2];
   end

   umd_window #(.WINDOW(DEV_WINDOW)) u_dev_window (
      .clock      (clock),
      .reset      (reset),
      .push_valid (ddiv_valid),
      .push_value (dev_value),
      .out_valid  (vwin_valid),
      .out_full   (vwin_full),
      .out_sum    (vwin_sum)
   );

   umd_mean_div #(.WINDOW(DEV_WINDOW)) u_dev_mean (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vwin_valid && vwin_full),
      .in_sum    (vwin_sum),
      .out_valid (vdiv_valid),
      .out_mean  (vdiv_mean)
   );

   umd_hit_tracker u_hit_tracker (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (vdiv_valid),
      .mean_distance  (mean_d_pipe_ff[3]),
      .mean_deviation (vdiv_mean),
      .threshold      (thr_ff),
      .hits           (hits_ff),
      .res_valid      (res_valid),
      .res_data       (res_data)
   );

   umd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .pop       (rsp_tready),
      .not_empty (fifo_not_empty),
      .head_data (head_data),
      .count     (fifo_count)
   );

   assign rsp_tvalid = fifo_not_empty;
   assign rsp_tdata  = umd_pkg::RSP_DAT_W'(head_data);

   // the credit scheme must keep the fifo from overflowing
   `UMD_ASSERT_IMP(a_fifo_room, clock, reset, res_valid,
                   fifo_count < umd_pkg::RSP_CNT_W'(umd_pkg::RSP_DEPTH))

   // owed items never exceed the fifo depth
   `UMD_ASSERT_IMP(a_credit_bound, clock, reset, 1'b1,
                   credit <= CREDIT_W'(umd_pkg::RSP_DEPTH))

   // a zero count with a nonzero limit always means the motion has ended
   `UMD_ASSERT_IMP(a_zero_count_idle, clock, reset,
                   res_valid && (res_data.hit_count == '0) && (hits_ff != '0),
                   !res_data.motion)

   // a sample taken now is marked in flight in the next cycle
   `UMD_ASSERT_NEXT(a_mark_follows, clock, reset, sample_take, mark_ff[0])

endmodule
